>>> hdl/c2d_pkg.sv
// Shared constants, types and address functions of the 2D convolution engine.
package c2d_pkg;

	localparam int MAX_IN_CHANNELS  = 16;
	localparam int MAX_OUT_CHANNELS = 16;
	localparam int MAX_ROWS         = 32;
	localparam int MAX_COLS         = 32;
	localparam int MAX_RADIUS       = 2;
	localparam int KDIM             = 2 * MAX_RADIUS + 1;

	localparam int ACT_DEPTH = MAX_IN_CHANNELS * MAX_ROWS * MAX_COLS;
	localparam int WGT_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * KDIM * KDIM;
	localparam int ACT_AW    = $clog2(ACT_DEPTH);
	localparam int WGT_AW    = $clog2(WGT_DEPTH);
	localparam int BIAS_AW   = 4;

	localparam int DATA_W = 16;
	localparam int PROD_W = 2 * DATA_W;
	localparam int ACC_W  = PROD_W + $clog2(MAX_IN_CHANNELS * KDIM * KDIM) + 1;
	localparam int FRAC_SHIFT = 12;

	localparam logic [1:0] OP_WRITE_WEIGHT     = 2'd0;
	localparam logic [1:0] OP_WRITE_BIAS       = 2'd1;
	localparam logic [1:0] OP_WRITE_ACTIVATION = 2'd2;
	localparam logic [1:0] OP_COMPUTE          = 2'd3;

	localparam logic [2:0] REG_INPUT_CHANNELS  = 3'd0;
	localparam logic [2:0] REG_OUTPUT_CHANNELS = 3'd1;
	localparam logic [2:0] REG_IMAGE_ROWS      = 3'd2;
	localparam logic [2:0] REG_IMAGE_COLS      = 3'd3;
	localparam logic [2:0] REG_KERNEL_RADIUS   = 3'd4;

	typedef struct packed {
		logic load;
		logic tap;
	} mac_ctrl_t;

	typedef struct packed {
		logic                     act_we;
		logic                     wgt_we;
		logic                     bias_we;
		logic [ACT_AW-1:0]        act_addr;
		logic [WGT_AW-1:0]        wgt_addr;
		logic [BIAS_AW-1:0]       bias_addr;
		logic signed [DATA_W-1:0] data;
	} store_wr_t;

	function automatic logic [ACT_AW-1:0] act_addr(input int ic, input int r, input int q);
		return ACT_AW'((ic * MAX_ROWS + r) * MAX_COLS + q);
	endfunction

	function automatic logic [WGT_AW-1:0] wgt_addr(input int oc, input int ic,
		input int tr, input int tc);
		return WGT_AW'(((oc * MAX_IN_CHANNELS + ic) * KDIM + tr) * KDIM + tc);
	endfunction

endpackage

>>> hdl/c2d_store.sv
// Activation, weight and bias memories with registered reads.
module c2d_store (
	input  logic                               clk,
	input  c2d_pkg::store_wr_t                 wr,
	input  logic [c2d_pkg::ACT_AW-1:0]         act_raddr,
	input  logic [c2d_pkg::WGT_AW-1:0]         wgt_raddr,
	input  logic [c2d_pkg::BIAS_AW-1:0]        bias_raddr,
	output logic signed [c2d_pkg::DATA_W-1:0]  act_rdata,
	output logic signed [c2d_pkg::DATA_W-1:0]  wgt_rdata,
	output logic signed [c2d_pkg::DATA_W-1:0]  bias_rdata
);
	import c2d_pkg::*;

	logic signed [DATA_W-1:0] act_mem  [ACT_DEPTH];
	logic signed [DATA_W-1:0] wgt_mem  [WGT_DEPTH];
	logic signed [DATA_W-1:0] bias_mem [MAX_OUT_CHANNELS];

	always_ff @(posedge clk) begin
		if (wr.act_we) begin
			act_mem[wr.act_addr] <= wr.data;
		end
		act_rdata <= act_mem[act_raddr];
	end

	always_ff @(posedge clk) begin
		if (wr.wgt_we) begin
			wgt_mem[wr.wgt_addr] <= wr.data;
		end
		wgt_rdata <= wgt_mem[wgt_raddr];
	end

	always_ff @(posedge clk) begin
		if (wr.bias_we) begin
			bias_mem[wr.bias_addr] <= wr.data;
		end
		bias_rdata <= bias_mem[bias_raddr];
	end

endmodule

>>> hdl/c2d_mac.sv
// Shared multiply-accumulate unit with output shift and saturation.
module c2d_mac (
	input  logic                               clk,
	input  logic                               arst_n,
	input  c2d_pkg::mac_ctrl_t                 ctrl,
	input  logic signed [c2d_pkg::DATA_W-1:0]  act,
	input  logic signed [c2d_pkg::DATA_W-1:0]  wgt,
	input  logic signed [c2d_pkg::DATA_W-1:0]  bias,
	output logic signed [c2d_pkg::DATA_W-1:0]  result,
	output logic                               saturated,
	output logic                               busy
);
	import c2d_pkg::*;

	localparam int SHIFT_W = ACC_W - FRAC_SHIFT;

	mac_ctrl_t                ctrl_s1;
	logic                     tap_s2;
	logic signed [PROD_W-1:0] product_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [SHIFT_W-1:0] shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			tap_s2  <= 1'b0;
		end else begin
			ctrl_s1 <= ctrl;
			tap_s2  <= ctrl_s1.tap;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_s1.tap) begin
			product_s2 <= act * wgt;
		end
		if (ctrl_s1.load) begin
			acc_q <= ACC_W'(bias) <<< FRAC_SHIFT;
		end else if (tap_s2) begin
			acc_q <= acc_q + ACC_W'(product_s2);
		end
	end

	assign shifted = SHIFT_W'(acc_q >>> FRAC_SHIFT);
	assign busy    = ctrl_s1.load | ctrl_s1.tap | tap_s2;

	always_comb begin
		saturated = 1'b1;
		if (shifted > SHIFT_W'(signed'(32767))) begin
			result = 16'sh7FFF;
		end else if (shifted < -SHIFT_W'(signed'(32768))) begin
			result = -16'sh8000;
		end else begin
			result    = DATA_W'(shifted);
			saturated = 1'b0;
		end
	end

endmodule

>>> hdl/conv2d_same_padding_mac.sv
// Top level of the multichannel 2D convolution engine with zero padding.
// Items write a weight, a bias or an activation into on-chip memory, or request
// one output element at (out_channel, row, col). A request walks the configured
// input channels and the (2r+1)^2 kernel taps through one shared multiply-accumulate
// unit at one tap per cycle; taps outside the image take their step without
// accumulating. A request outside the configured sizes finishes with status set.
// The input side stalls while a request is in progress; the finished result sits
// in an output register, so the next item is accepted while it waits to be taken.
// Memories hold garbage until written.
module conv2d_same_padding_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [5:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic [3:0]         out_channel,
	input  logic [3:0]         in_channel,
	input  logic [4:0]         row,
	input  logic [4:0]         col,
	input  logic signed [15:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] result,
	output logic               saturated,
	output logic               status
);
	import c2d_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q;

	logic [4:0] in_ch_q, out_ch_q;
	logic [5:0] rows_q, cols_q;
	logic [1:0] radius_q;

	logic [4:0] nin, nout;
	logic [5:0] h, w;
	logic [1:0] rad;
	logic [2:0] kmax;

	logic [3:0] oc_q, c_q;
	logic [4:0] row_q, col_q;
	logic [2:0] kr_q, kc_q;
	logic       oor_q;

	logic              accept, start, oor;
	logic signed [7:0] r_s, q_s;
	logic              in_image;

	store_wr_t                wr;
	mac_ctrl_t                ctrl;
	logic [ACT_AW-1:0]        act_raddr;
	logic [WGT_AW-1:0]        wgt_raddr;
	logic signed [DATA_W-1:0] act_rdata, wgt_rdata, bias_rdata;
	logic signed [DATA_W-1:0] mac_result;
	logic                     mac_sat, mac_busy;
	logic                     out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch_q  <= 5'd1;
			out_ch_q <= 5'd1;
			rows_q   <= 6'd32;
			cols_q   <= 6'd32;
			radius_q <= 2'd1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_INPUT_CHANNELS:  in_ch_q  <= cfg_data[4:0];
				REG_OUTPUT_CHANNELS: out_ch_q <= cfg_data[4:0];
				REG_IMAGE_ROWS:      rows_q   <= cfg_data;
				REG_IMAGE_COLS:      cols_q   <= cfg_data;
				REG_KERNEL_RADIUS:   radius_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		nin  = (in_ch_q == '0) ? 5'd1 : (in_ch_q > 5'(MAX_IN_CHANNELS)) ? 5'(MAX_IN_CHANNELS)
			: in_ch_q;
		nout = (out_ch_q == '0) ? 5'd1
			: (out_ch_q > 5'(MAX_OUT_CHANNELS)) ? 5'(MAX_OUT_CHANNELS) : out_ch_q;
		h    = (rows_q == '0) ? 6'd1 : (rows_q > 6'(MAX_ROWS)) ? 6'(MAX_ROWS) : rows_q;
		w    = (cols_q == '0) ? 6'd1 : (cols_q > 6'(MAX_COLS)) ? 6'(MAX_COLS) : cols_q;
		rad  = (radius_q > 2'(MAX_RADIUS)) ? 2'(MAX_RADIUS) : radius_q;
		kmax = {rad, 1'b0};
	end

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign start    = accept && (operation == OP_COMPUTE);
	assign oor      = ({1'b0, out_channel} >= nout) || ({1'b0, row} >= h)
		|| ({1'b0, col} >= w);

	always_comb begin
		wr.act_we    = accept && (operation == OP_WRITE_ACTIVATION) && (int'(in_channel)
			< MAX_IN_CHANNELS) && (int'(row) < MAX_ROWS) && (int'(col) < MAX_COLS);
		wr.wgt_we    = accept && (operation == OP_WRITE_WEIGHT) && (int'(out_channel)
			< MAX_OUT_CHANNELS) && (int'(in_channel) < MAX_IN_CHANNELS)
			&& (int'(row) < KDIM) && (int'(col) < KDIM);
		wr.bias_we   = accept && (operation == OP_WRITE_BIAS)
			&& (int'(out_channel) < MAX_OUT_CHANNELS);
		wr.act_addr  = act_addr(int'(in_channel), int'(row), int'(col));
		wr.wgt_addr  = wgt_addr(int'(out_channel), int'(in_channel), int'(row), int'(col));
		wr.bias_addr = out_channel;
		wr.data      = value;
	end

	always_comb begin
		r_s      = $signed({3'b0, row_q}) + $signed({5'b0, kr_q}) - $signed({6'b0, rad});
		q_s      = $signed({3'b0, col_q}) + $signed({5'b0, kc_q}) - $signed({6'b0, rad});
		in_image = !r_s[7] && (r_s[6:0] < {1'b0, h}) && !q_s[7] && (q_s[6:0] < {1'b0, w});
		act_raddr = act_addr(int'(c_q), int'(r_s[4:0]), int'(q_s[4:0]));
		wgt_raddr = wgt_addr(int'(oc_q), int'(c_q), int'(kr_q), int'(kc_q));
		ctrl.load = start;
		ctrl.tap  = (state_q == ST_RUN) && in_image;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			c_q     <= '0;
			kr_q    <= '0;
			kc_q    <= '0;
			oor_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						oor_q   <= oor;
						c_q     <= '0;
						kr_q    <= '0;
						kc_q    <= '0;
						state_q <= oor ? ST_DONE : ST_RUN;
					end
				end
				ST_RUN: begin
					if (kc_q != kmax) begin
						kc_q <= kc_q + 3'd1;
					end else begin
						kc_q <= '0;
						if (kr_q != kmax) begin
							kr_q <= kr_q + 3'd1;
						end else begin
							kr_q <= '0;
							if (c_q == 4'(nin - 5'd1)) begin
								state_q <= ST_DRAIN;
							end else begin
								c_q <= c_q + 4'd1;
							end
						end
					end
				end
				ST_DRAIN: begin
					if (!mac_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			oc_q  <= out_channel;
			row_q <= row;
			col_q <= col;
		end
	end

	c2d_store u_store (
		.clk        (clk),
		.wr         (wr),
		.act_raddr  (act_raddr),
		.wgt_raddr  (wgt_raddr),
		.bias_raddr (out_channel),
		.act_rdata  (act_rdata),
		.wgt_rdata  (wgt_rdata),
		.bias_rdata (bias_rdata)
	);

	c2d_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.act       (act_rdata),
		.wgt       (wgt_rdata),
		.bias      (bias_rdata),
		.result    (mac_result),
		.saturated (mac_sat),
		.busy      (mac_busy)
	);

	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			result    <= oor_q ? '0 : mac_result;
			saturated <= oor_q ? 1'b0 : mac_sat;
			status    <= oor_q;
		end
	end

endmodule

>>> bench/testbench.sv
// Drives the 2D convolution engine with directed and random items and checks each output element.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import c2d_pkg::*;

	localparam logic STATUS_OK           = 1'b0;
	localparam logic STATUS_OUT_OF_RANGE = 1'b1;
	localparam int   ITEM_GOAL           = 1450;
	localparam int   PHASE_ITEMS         = 100;
	localparam int   SETTLE_CYCLES       = 16;
	localparam int   HOLD_OFF_CYCLES     = 600;
	localparam int   PRINT_LIMIT         = 40;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [1:0]         op;
		logic [3:0]         oc;
		logic [3:0]         ic;
		logic [4:0]         row;
		logic [4:0]         col;
		logic signed [15:0] value;
	} conv_item_t;

	typedef struct packed {
		logic signed [15:0] result;
		logic               saturated;
		logic               status;
	} conv_out_t;

	typedef struct packed {
		conv_item_t item;
		logic       typed;
		conv_out_t  expected;
	} directed_row_t;

	typedef struct packed {
		logic [5:0] in_ch;
		logic [5:0] out_ch;
		logic [5:0] rows;
		logic [5:0] cols;
		logic [5:0] radius;
	} setting_t;

	localparam conv_out_t NO_OUT      = '0;
	localparam conv_out_t CLIP_HIGH   = '{16'sh7FFF, 1'b1, STATUS_OK};
	localparam conv_out_t CLIP_LOW    = '{16'sh8000, 1'b1, STATUS_OK};
	localparam conv_out_t RANGE_ERROR = '{16'sd0, 1'b0, STATUS_OUT_OF_RANGE};

	localparam directed_row_t DIRECTED_ROWS [24] = '{
		'{'{OP_WRITE_BIAS,       4'd0,  4'd0,  5'd0,  5'd0,  16'sh7FFF}, 1'b0, NO_OUT},
		'{'{OP_WRITE_WEIGHT,     4'd0,  4'd0,  5'd1,  5'd1,  16'sh7FFF}, 1'b0, NO_OUT},
		'{'{OP_WRITE_WEIGHT,     4'd0,  4'd0,  5'd1,  5'd2,  16'sh7FFF}, 1'b0, NO_OUT},
		'{'{OP_WRITE_WEIGHT,     4'd0,  4'd0,  5'd2,  5'd1,  16'sh7FFF}, 1'b0, NO_OUT},
		'{'{OP_WRITE_WEIGHT,     4'd0,  4'd0,  5'd2,  5'd2,  16'sh7FFF}, 1'b0, NO_OUT},
		'{'{OP_WRITE_ACTIVATION, 4'd0,  4'd0,  5'd0,  5'd0,  16'sh7FFF}, 1'b0, NO_OUT},
		'{'{OP_WRITE_ACTIVATION, 4'd0,  4'd0,  5'd0,  5'd1,  16'sh7FFF}, 1'b0, NO_OUT},
		'{'{OP_WRITE_ACTIVATION, 4'd0,  4'd0,  5'd1,  5'd0,  16'sh7FFF}, 1'b0, NO_OUT},
		'{'{OP_WRITE_ACTIVATION, 4'd0,  4'd0,  5'd1,  5'd1,  16'sh7FFF}, 1'b0, NO_OUT},
		'{'{OP_COMPUTE,          4'd0,  4'd0,  5'd0,  5'd0,  16'sd0},    1'b1, CLIP_HIGH},
		'{'{OP_WRITE_BIAS,       4'd0,  4'd0,  5'd0,  5'd0,  16'sh8000}, 1'b0, NO_OUT},
		'{'{OP_WRITE_ACTIVATION, 4'd0,  4'd0,  5'd0,  5'd0,  16'sh8000}, 1'b0, NO_OUT},
		'{'{OP_WRITE_ACTIVATION, 4'd0,  4'd0,  5'd0,  5'd1,  16'sh8000}, 1'b0, NO_OUT},
		'{'{OP_WRITE_ACTIVATION, 4'd0,  4'd0,  5'd1,  5'd0,  16'sh8000}, 1'b0, NO_OUT},
		'{'{OP_WRITE_ACTIVATION, 4'd0,  4'd0,  5'd1,  5'd1,  16'sh8000}, 1'b0, NO_OUT},
		'{'{OP_COMPUTE,          4'd0,  4'd0,  5'd0,  5'd0,  16'shFFFF}, 1'b1, CLIP_LOW},
		'{'{OP_COMPUTE,          4'd15, 4'd15, 5'd31, 5'd31, 16'sh7FFF}, 1'b1, RANGE_ERROR},
		'{'{OP_COMPUTE,          4'd1,  4'd0,  5'd0,  5'd0,  16'sd0},    1'b1, RANGE_ERROR},
		'{'{OP_WRITE_WEIGHT,     4'd15, 4'd15, 5'd4,  5'd4,  16'sh8000}, 1'b0, NO_OUT},
		'{'{OP_WRITE_WEIGHT,     4'd0,  4'd0,  5'd5,  5'd1,  16'sd0},    1'b0, NO_OUT},
		'{'{OP_WRITE_WEIGHT,     4'd0,  4'd0,  5'd1,  5'd31, 16'sd0},    1'b0, NO_OUT},
		'{'{OP_WRITE_ACTIVATION, 4'd0,  4'd15, 5'd31, 5'd31, 16'sh7FFF}, 1'b0, NO_OUT},
		'{'{OP_WRITE_BIAS,       4'd15, 4'd0,  5'd0,  5'd0,  16'sd1},    1'b0, NO_OUT},
		'{'{OP_COMPUTE,          4'd0,  4'd0,  5'd0,  5'd0,  16'sd0},    1'b0, NO_OUT}
	};

	localparam setting_t FIXED_SETTINGS [8] = '{
		'{6'd2,  6'd3,  6'd8,  6'd8,  6'd1},
		'{6'd0,  6'd0,  6'd1,  6'd1,  6'd0},
		'{6'd3,  6'd16, 6'd5,  6'd7,  6'd2},
		'{6'd31, 6'd2,  6'd32, 6'd32, 6'd0},
		'{6'd1,  6'd63, 6'd63, 6'd1,  6'd3},
		'{6'd16, 6'd1,  6'd3,  6'd3,  6'd1},
		'{6'd4,  6'd4,  6'd32, 6'd2,  6'd2},
		'{6'd32, 6'd17, 6'd0,  6'd40, 6'd2}
	};

	logic               clk;
	logic               arst_n      = 1'b0;
	logic               cfg_write   = 1'b0;
	logic [2:0]         cfg_index   = REG_INPUT_CHANNELS;
	logic [5:0]         cfg_data    = '0;
	logic               in_valid    = 1'b0;
	logic               in_stall;
	logic [1:0]         operation   = OP_WRITE_WEIGHT;
	logic [3:0]         out_channel = '0;
	logic [3:0]         in_channel  = '0;
	logic [4:0]         row         = '0;
	logic [4:0]         col         = '0;
	logic signed [15:0] value       = '0;
	logic               out_valid;
	logic               out_stall   = 1'b0;
	logic signed [15:0] result;
	logic               saturated;
	logic               status;

	conv2d_same_padding_mac dut (.*);

	logic signed [15:0] act_mem  [ACT_DEPTH];
	logic signed [15:0] wgt_mem  [WGT_DEPTH];
	logic signed [15:0] bias_mem [MAX_OUT_CHANNELS];
	bit                 act_set  [ACT_DEPTH];
	bit                 wgt_set  [WGT_DEPTH];
	bit                 bias_set [MAX_OUT_CHANNELS];

	logic [4:0] in_ch_reg  = 5'd1;
	logic [4:0] out_ch_reg = 5'd1;
	logic [5:0] rows_reg   = 6'd32;
	logic [5:0] cols_reg   = 6'd32;
	logic [1:0] radius_reg = 2'd1;

	conv_out_t pending_outputs [$];
	int        mismatches      = 0;
	int        items_sent      = 0;
	int        sender_idle_pct = 0;
	int        stall_pct       = 0;
	int        hold_left       = 0;

	function automatic int clamp_count(int v, int hi);
		return (v < 1) ? 1 : (v > hi) ? hi : v;
	endfunction

	function automatic int n_in();
		return clamp_count(int'(in_ch_reg), MAX_IN_CHANNELS);
	endfunction

	function automatic int n_out();
		return clamp_count(int'(out_ch_reg), MAX_OUT_CHANNELS);
	endfunction

	function automatic int n_rows();
		return clamp_count(int'(rows_reg), MAX_ROWS);
	endfunction

	function automatic int n_cols();
		return clamp_count(int'(cols_reg), MAX_COLS);
	endfunction

	function automatic int n_radius();
		return (int'(radius_reg) > MAX_RADIUS) ? MAX_RADIUS : int'(radius_reg);
	endfunction

	function automatic int act_slot(int ic, int r, int q);
		return (ic * MAX_ROWS + r) * MAX_COLS + q;
	endfunction

	function automatic int wgt_slot(int oc, int ic, int tr, int tc);
		return ((oc * MAX_IN_CHANNELS + ic) * KDIM + tr) * KDIM + tc;
	endfunction

	function automatic conv_out_t predict_element(int oc, int r0, int c0);
		conv_out_t o;
		longint    acc;
		int        rad, r, q, c, kr, kc;
		o = '0;
		if (oc >= n_out() || r0 >= n_rows() || c0 >= n_cols()) begin
			o.status = STATUS_OUT_OF_RANGE;
			return o;
		end
		rad = n_radius();
		acc = longint'(bias_mem[oc]) <<< FRAC_SHIFT;
		for (c = 0; c < n_in(); c++)
			for (kr = -rad; kr <= rad; kr++)
				for (kc = -rad; kc <= rad; kc++) begin
					r = r0 + kr;
					q = c0 + kc;
					if (r >= 0 && r < n_rows() && q >= 0 && q < n_cols())
						acc += longint'(act_mem[act_slot(c, r, q)])
							* longint'(wgt_mem[wgt_slot(oc, c, kr + rad, kc + rad)]);
				end
		acc = acc >>> FRAC_SHIFT;
		if (acc > 32767) begin
			o.result = 16'sh7FFF;
			o.saturated = 1'b1;
		end else if (acc < -32768) begin
			o.result = 16'sh8000;
			o.saturated = 1'b1;
		end else begin
			o.result = acc[15:0];
		end
		o.status = STATUS_OK;
		return o;
	endfunction

	function automatic void apply_item(conv_item_t it, logic typed, conv_out_t typed_out);
		int slot;
		case (it.op)
			OP_WRITE_WEIGHT: begin
				if (it.row < KDIM && it.col < KDIM) begin
					slot = wgt_slot(it.oc, it.ic, it.row, it.col);
					wgt_mem[slot] = it.value;
					wgt_set[slot] = 1'b1;
				end
			end
			OP_WRITE_BIAS: begin
				bias_mem[it.oc] = it.value;
				bias_set[it.oc] = 1'b1;
			end
			OP_WRITE_ACTIVATION: begin
				slot = act_slot(it.ic, it.row, it.col);
				act_mem[slot] = it.value;
				act_set[slot] = 1'b1;
			end
			default: begin
				pending_outputs.push_back(typed ? typed_out
					: predict_element(it.oc, it.row, it.col));
			end
		endcase
		items_sent++;
	endfunction

	function automatic logic signed [15:0] pick_value();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			return 16'($urandom_range(0, 1023)) - 16'sd512;
		if (sel < 85)
			return 16'($urandom);
		case ($urandom_range(0, 3))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sd0;
			default: return -16'sd1;
		endcase
	endfunction

	function automatic setting_t random_setting();
		setting_t s;
		int       rad, span;
		s.in_ch  = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 4));
		s.out_ch = 6'($urandom);
		s.rows   = 6'($urandom);
		s.cols   = 6'($urandom);
		s.radius = 6'($urandom_range(0, 3));
		rad = (int'(s.radius[1:0]) > MAX_RADIUS) ? MAX_RADIUS : int'(s.radius[1:0]);
		span = 2 * rad + 1;
		if (clamp_count(int'(s.in_ch[4:0]), MAX_IN_CHANNELS) * span * span > 50)
			s.in_ch = 6'($urandom_range(1, 2));
		return s;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (mismatches < PRINT_LIMIT)
			$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
		mismatches++;
	endtask

	task automatic check_output();
		conv_out_t want;
		if (pending_outputs.size() == 0) begin
			report_mismatch("unexpected output, result", int'(result), 0);
			return;
		end
		want = pending_outputs.pop_front();
		if (result !== want.result)
			report_mismatch("result", int'(result), int'(want.result));
		if (saturated !== want.saturated)
			report_mismatch("saturated", int'(saturated), int'(want.saturated));
		if (status !== want.status)
			report_mismatch("status", int'(status), int'(want.status));
	endtask

	task automatic offer_item(conv_item_t it, logic typed, conv_out_t typed_out);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		operation   <= it.op;
		out_channel <= it.oc;
		in_channel  <= it.ic;
		row         <= it.row;
		col         <= it.col;
		value       <= it.value;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		apply_item(it, typed, typed_out);
	endtask

	task automatic send(logic [1:0] op, int oc, int ic, int r, int c, logic signed [15:0] v);
		conv_item_t it;
		it.op    = op;
		it.oc    = 4'(oc);
		it.ic    = 4'(ic);
		it.row   = 5'(r);
		it.col   = 5'(c);
		it.value = v;
		offer_item(it, 1'b0, NO_OUT);
	endtask

	// write every entry that the element will read and that holds nothing yet
	task automatic prime_element(int oc, int r0, int c0);
		int rad, r, q, c, kr, kc;
		rad = n_radius();
		if (!bias_set[oc])
			send(OP_WRITE_BIAS, oc, $urandom_range(0, 15), 0, 0, pick_value());
		for (c = 0; c < n_in(); c++)
			for (kr = -rad; kr <= rad; kr++)
				for (kc = -rad; kc <= rad; kc++) begin
					r = r0 + kr;
					q = c0 + kc;
					if (r >= 0 && r < n_rows() && q >= 0 && q < n_cols()) begin
						if (!act_set[act_slot(c, r, q)])
							send(OP_WRITE_ACTIVATION, $urandom_range(0, 15), c, r, q,
								pick_value());
						if (!wgt_set[wgt_slot(oc, c, kr + rad, kc + rad)])
							send(OP_WRITE_WEIGHT, oc, c, kr + rad, kc + rad, pick_value());
					end
				end
	endtask

	task automatic send_stray_compute();
		conv_item_t it;
		int         dim;
		it.op    = OP_COMPUTE;
		it.oc    = 4'($urandom);
		it.ic    = 4'($urandom);
		it.row   = 5'($urandom);
		it.col   = 5'($urandom);
		it.value = 16'($urandom);
		if (it.oc < n_out() && it.row < n_rows() && it.col < n_cols()) begin
			dim = $urandom_range(0, 2);
			if (dim == 0 && n_out() < MAX_OUT_CHANNELS)
				it.oc = 4'($urandom_range(n_out(), MAX_OUT_CHANNELS - 1));
			else if (dim <= 1 && n_rows() < MAX_ROWS)
				it.row = 5'($urandom_range(n_rows(), MAX_ROWS - 1));
			else if (n_cols() < MAX_COLS)
				it.col = 5'($urandom_range(n_cols(), MAX_COLS - 1));
			else if (n_out() < MAX_OUT_CHANNELS)
				it.oc = 4'($urandom_range(n_out(), MAX_OUT_CHANNELS - 1));
			else
				it.row = 5'($urandom_range(n_rows(), MAX_ROWS - 1));
		end
		offer_item(it, 1'b0, NO_OUT);
	endtask

	task automatic random_step();
		int  sel, oc, r, c, rad;
		logic [1:0] op;
		sel = $urandom_range(0, 99);
		if (sel >= 45 && sel < 55
			&& (n_out() < MAX_OUT_CHANNELS || n_rows() < MAX_ROWS || n_cols() < MAX_COLS)) begin
			send_stray_compute();
		end else if (sel < 55) begin
			oc = $urandom_range(0, n_out() - 1);
			r  = $urandom_range(0, n_rows() - 1);
			c  = $urandom_range(0, n_cols() - 1);
			prime_element(oc, r, c);
			send(OP_COMPUTE, oc, $urandom_range(0, 15), r, c, 16'($urandom));
		end else if (sel < 80) begin
			op  = 2'($urandom_range(0, 2));
			rad = n_radius();
			if (op == OP_WRITE_WEIGHT)
				send(op, $urandom_range(0, n_out() - 1), $urandom_range(0, n_in() - 1),
					$urandom_range(0, 2 * rad), $urandom_range(0, 2 * rad), pick_value());
			else
				send(op, $urandom_range(0, n_out() - 1), $urandom_range(0, n_in() - 1),
					$urandom_range(0, n_rows() - 1), $urandom_range(0, n_cols() - 1),
					pick_value());
		end else begin
			send(2'($urandom_range(0, 2)), $urandom_range(0, 15), $urandom_range(0, 15),
				$urandom_range(0, 31), $urandom_range(0, 31), pick_value());
		end
	endtask

	task automatic write_register(logic [2:0] idx, logic [5:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_INPUT_CHANNELS:  in_ch_reg  = data[4:0];
			REG_OUTPUT_CHANNELS: out_ch_reg = data[4:0];
			REG_IMAGE_ROWS:      rows_reg   = data;
			REG_IMAGE_COLS:      cols_reg   = data;
			REG_KERNEL_RADIUS:   radius_reg = data[1:0];
			default: ;
		endcase
	endtask

	task automatic load_setting(setting_t s);
		write_register(REG_INPUT_CHANNELS, s.in_ch);
		write_register(REG_OUTPUT_CHANNELS, s.out_ch);
		write_register(REG_IMAGE_ROWS, s.rows);
		write_register(REG_IMAGE_COLS, s.cols);
		write_register(REG_KERNEL_RADIUS, s.radius);
		write_register(3'($urandom_range(int'(REG_KERNEL_RADIUS) + 1, 7)), 6'($urandom));
		cfg_write <= 1'b0;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("conv2d_same_padding_mac verification failed");
		$finish;
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				check_output();
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	initial begin
		int         i, phase, start;
		setting_t   s;
		idle_mode_t mode;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (i = 0; i < $size(DIRECTED_ROWS); i++)
			offer_item(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed,
				DIRECTED_ROWS[i].expected);
		for (phase = 0; items_sent < ITEM_GOAL; phase++) begin
			s = (phase < $size(FIXED_SETTINGS)) ? FIXED_SETTINGS[phase] : random_setting();
			settle();
			load_setting(s);
			mode = idle_mode_t'(phase % 4);
			case (mode)
				IDLE_NONE: begin
					sender_idle_pct = 0;
					stall_pct = 0;
				end
				IDLE_SENDER: begin
					sender_idle_pct = 77;
					stall_pct = 0;
				end
				IDLE_RECEIVER: begin
					sender_idle_pct = 0;
					stall_pct = 77;
				end
				default: begin
					sender_idle_pct = 8;
					stall_pct = 8;
				end
			endcase
			// hold the output side off so the engine backs up into its input
			if (phase == 0)
				hold_left = HOLD_OFF_CYCLES;
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS)
				random_step();
		end
		in_valid <= 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("conv2d_same_padding_mac verification clean");
		else
			$display("conv2d_same_padding_mac verification failed");
		$finish;
	end
endmodule

>>> conv2d_same_padding_mac.f
hdl/c2d_pkg.sv
hdl/c2d_store.sv
hdl/c2d_mac.sv
hdl/conv2d_same_padding_mac.sv
bench/testbench.sv
